>>> sv/page_range_allocator_fit_top_defines.svh
// Assertion macros used by the allocator checker
`ifndef PAGE_RANGE_ALLOCATOR_FIT_TOP_DEFINES_SVH
`define PAGE_RANGE_ALLOCATOR_FIT_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PRAF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// next-cycle implication, disabled in reset
`define PRAF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

>>> sv/praf_pkg.sv
// Types and codes of the page range allocator
`default_nettype none
package praf_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] size_bytes;
        logic [19:0] address_page;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] start_page;
        logic [10:0] freed_pages;
        logic [10:0] break_out;
    } t_res;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

endpackage
`default_nettype wire

>>> sv/page_range_allocator_fit_top.sv
// Page range allocator: exact fit, else largest fit, else break extension
//
// Request: drive i_req and pulse i_start while o_busy is low; the transfer
// happens on that edge. Each request gives exactly one result: o_done is high
// for one cycle with o_res valid. There is no back pressure on results.
// Config: i_cfg_valid/o_cfg_ready with i_cfg_index (0 base page, 1 limit) and
// i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Steps from transfer to o_done:
//   zero size, oversize, range error:   result straight from idle
//   allocate: page count, page map scan up to brk, fit choice, page mark
//   free:     length read, page clear, length table rescan up to brk
// brk is the break mark; both scans read one memory entry per cycle through
// the registered read port of the page map or the length table.
// After reset a clearing pass over all NUM_PAGES entries zeroes both memories;
// o_busy is high during it, configuration writes are still taken.
// The break mark reads zero after reset.
`default_nettype none
module page_range_allocator_fit_top #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire praf_pkg::t_req  i_req,
    output logic                 o_done,
    output praf_pkg::t_res       o_res,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [19:0]     i_cfg_data
);

    localparam int AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW  = $clog2(NUM_PAGES + 1);
    localparam int QW  = 33;
    localparam logic [63:0] ROUND_MAX = (64'hFFFF_FFFF / PAGE_BYTES) * PAGE_BYTES;
    localparam logic [63:0] REGION_BYTES = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
    // anything larger can never be placed, so it fails at once
    localparam logic [63:0] MAX_SIZE = (ROUND_MAX < REGION_BYTES) ? ROUND_MAX : REGION_BYTES;
    localparam logic [QW-1:0] PB_M1 = QW'(PAGE_BYTES - 1);
    localparam logic [CW-1:0] LAST = CW'(NUM_PAGES - 1);
    // page count by reciprocal multiply; exact while x_max * PAGE_BYTES <= 2^KS
    localparam logic [63:0] X_MAX = MAX_SIZE + 64'(PAGE_BYTES) - 64'd1;
    localparam int XW = $clog2(X_MAX + 64'd1);
    localparam int DL = $clog2(PAGE_BYTES);
    localparam int KS = XW + DL;
    localparam logic [63:0] RECIP = ((64'd1 << KS) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam int MW = $clog2(RECIP + 64'd1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_EXT   = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_FREAD = 4'd6;
    localparam logic [3:0] S_FLEN  = 4'd7;
    localparam logic [3:0] S_FCLR  = 4'd8;
    localparam logic [3:0] S_FSCAN = 4'd9;

    logic [3:0]    r_state;
    logic [19:0]   r_base;
    logic [10:0]   r_limit;
    logic [CW-1:0] r_brk;
    logic [QW-1:0] r_num;
    logic [QW-1:0] r_pages;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_end;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_run_start;
    logic [CW-1:0] r_run_len;
    logic [AW-1:0] r_best_off;
    logic [CW-1:0] r_best_len;
    logic          r_have_best;
    logic [CW-1:0] r_chosen;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_nb;
    logic          r_done;
    logic          n_done;
    praf_pkg::t_res r_res;

    // memories
    logic          mem_pu [NUM_PAGES];
    logic [CW-1:0] mem_al [NUM_PAGES];
    logic          pu_we, pu_wd, pu_q;
    logic [AW-1:0] pu_wa, pu_ra;
    logic          al_we;
    logic [CW-1:0] al_wd, al_q;
    logic [AW-1:0] al_wa, al_ra;

    logic [31:0]   lim32;
    logic [CW-1:0] limit_eff;
    logic          issue;
    logic [19:0]   off;
    logic [QW:0]   ext_sum;
    logic [CW:0]   end_sum;
    logic [XW+MW-1:0] quo_prod;
    logic          size_zero;
    logic          size_big;
    logic          free_bad;
    logic          req_fail;
    logic          ext_fail;
    logic          walk_last;
    logic          scan_stop;
    logic          run_end;

    always_comb begin
        lim32 = ({21'd0, r_limit} > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : {21'd0, r_limit};
        limit_eff = lim32[CW-1:0];
        issue = r_addr < r_brk;
        off = i_req.address_page - r_base;
        ext_sum = {{(QW + 1 - CW){1'b0}}, r_brk} + {1'b0, r_pages};
        end_sum = (CW + 1)'(r_rd_addr) + {1'b0, al_q};
        quo_prod = (XW + MW)'(r_num[XW-1:0]) * (XW + MW)'(RECIP);
        size_zero = (i_req.size_bytes == 32'd0);
        size_big = ({32'd0, i_req.size_bytes} > MAX_SIZE);
        free_bad = (i_req.address_page < r_base) || ({12'd0, off} >= 32'(limit_eff));
        req_fail = (i_req.operation == praf_pkg::OP_ALLOC) ? (size_zero || size_big) : free_bad;
        ext_fail = ext_sum > (QW + 1)'(limit_eff);
        walk_last = (r_addr + 1'b1 == r_end);
        scan_stop = !r_rd_vld && !issue;
        run_end = (r_rd_vld && pu_q) || scan_stop;
    end

    always_comb begin
        n_done = 1'b0;
        unique case (r_state)
            S_IDLE:  n_done = i_start && req_fail;
            S_EXT:   n_done = !r_have_best && ext_fail;
            S_MARK:  n_done = walk_last;
            S_FLEN:  n_done = (al_q == '0);
            S_FSCAN: n_done = scan_stop;
            default: ;
        endcase
    end

    always_comb begin
        pu_we = 1'b0;
        pu_wd = 1'b0;
        pu_wa = r_addr[AW-1:0];
        pu_ra = r_addr[AW-1:0];
        al_we = 1'b0;
        al_wd = '0;
        al_wa = r_addr[AW-1:0];
        al_ra = r_addr[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                pu_we = 1'b1;
                al_we = 1'b1;
            end
            S_MARK: begin
                pu_we = 1'b1;
                pu_wd = 1'b1;
                al_we = (r_addr == r_chosen);
                al_wd = r_pages[CW-1:0];
            end
            S_FCLR: begin
                pu_we = 1'b1;
                al_we = (r_addr == r_chosen);
            end
            S_FREAD: al_ra = r_chosen[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pu_we) begin
            mem_pu[pu_wa] <= pu_wd;
        end
        pu_q <= mem_pu[pu_ra];
    end

    always_ff @(posedge i_clk) begin
        if (al_we) begin
            mem_al[al_wa] <= al_wd;
        end
        al_q <= mem_al[al_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_num <= {1'b0, i_req.size_bytes} + PB_M1;
        end else if (r_state == S_DIV) begin
            r_pages <= QW'(quo_prod >> KS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_base      <= '0;
            r_limit     <= 11'd1024;
            r_brk       <= '0;
            r_addr      <= '0;
            r_done      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_run_len   <= '0;
            r_best_len  <= '0;
            r_have_best <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    praf_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                    praf_pkg::CFG_LIMIT: r_limit <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_res.start_page  <= 20'd0;
                        r_res.freed_pages <= 11'd0;
                        r_res.break_out   <= 11'(r_brk);
                        if (i_req.operation == praf_pkg::OP_ALLOC) begin
                            if (size_zero) begin
                                r_res.status <= praf_pkg::ST_ZERO;
                            end else if (size_big) begin
                                r_res.status <= praf_pkg::ST_NOSPACE;
                            end else begin
                                r_res.status <= praf_pkg::ST_OK;
                                r_state      <= S_DIV;
                            end
                        end else begin
                            if (free_bad) begin
                                r_res.status <= praf_pkg::ST_RANGE;
                            end else begin
                                r_res.status <= praf_pkg::ST_OK;
                                r_chosen     <= off[CW-1:0];
                                r_state      <= S_FREAD;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_addr      <= '0;
                    r_rd_vld    <= 1'b0;
                    r_run_len   <= '0;
                    r_best_len  <= '0;
                    r_have_best <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    r_rd_vld  <= issue;
                    r_rd_addr <= r_addr[AW-1:0];
                    if (run_end && QW'(r_run_len) == r_pages) begin
                        r_chosen <= CW'(r_run_start);
                        r_addr   <= CW'(r_run_start);
                        r_end    <= CW'(r_run_start) + r_pages[CW-1:0];
                        r_state  <= S_MARK;
                    end else if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_rd_vld && !pu_q) begin
                        if (r_run_len == '0) begin
                            r_run_start <= r_rd_addr;
                        end
                        r_run_len <= r_run_len + 1'b1;
                    end
                    // a free run ends at a used page or at the break
                    if (run_end) begin
                        r_run_len <= '0;
                        if (QW'(r_run_len) != r_pages) begin
                            if (QW'(r_run_len) >= r_pages && r_run_len > r_best_len) begin
                                r_best_off  <= r_run_start;
                                r_best_len  <= r_run_len;
                                r_have_best <= 1'b1;
                            end
                            if (!r_rd_vld) begin
                                r_state <= S_EXT;
                            end
                        end
                    end
                end
                S_EXT: begin
                    if (r_have_best) begin
                        r_chosen <= CW'(r_best_off);
                        r_addr   <= CW'(r_best_off);
                        r_end    <= CW'(r_best_off) + r_pages[CW-1:0];
                        r_state  <= S_MARK;
                    end else if (ext_fail) begin
                        r_res.status <= praf_pkg::ST_NOSPACE;
                        r_state      <= S_IDLE;
                    end else begin
                        r_chosen <= r_brk;
                        r_addr   <= r_brk;
                        r_end    <= ext_sum[CW-1:0];
                        r_brk    <= ext_sum[CW-1:0];
                        r_state  <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_addr <= r_addr + 1'b1;
                    if (walk_last) begin
                        r_res.start_page <= r_base + 20'(r_chosen);
                        r_res.break_out  <= 11'(r_brk);
                        r_state          <= S_IDLE;
                    end
                end
                S_FREAD: r_state <= S_FLEN;
                S_FLEN: begin
                    if (al_q == '0) begin
                        r_res.status <= praf_pkg::ST_NOTFOUND;
                        r_state      <= S_IDLE;
                    end else begin
                        r_len   <= al_q;
                        r_addr  <= r_chosen;
                        r_end   <= r_chosen + al_q;
                        r_state <= S_FCLR;
                    end
                end
                S_FCLR: begin
                    if (walk_last) begin
                        r_addr   <= '0;
                        r_rd_vld <= 1'b0;
                        r_nb     <= '0;
                        r_state  <= S_FSCAN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_FSCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_rd_vld  <= issue;
                    r_rd_addr <= r_addr[AW-1:0];
                    if (r_rd_vld && al_q != '0 && end_sum > {1'b0, r_nb}) begin
                        r_nb <= end_sum[CW-1:0];
                    end
                    if (scan_stop) begin
                        r_brk             <= r_nb;
                        r_res.freed_pages <= 11'(r_len);
                        r_res.break_out   <= 11'(r_nb);
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> sv/praf_checker.sv
// Port-level checks of the page range allocator, bound to the top level
`default_nettype none
`include "page_range_allocator_fit_top_defines.svh"
module praf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_start,
    input wire logic           o_busy,
    input wire logic           o_done,
    input wire praf_pkg::t_res o_res
);

    `PRAF_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `PRAF_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    `PRAF_ASSERT_IMP(a_fail_no_page, i_clk, i_rst_n, o_done && o_res.status != praf_pkg::ST_OK, o_res.start_page == 20'd0 && o_res.freed_pages == 11'd0)
    `PRAF_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, o_res.status <= praf_pkg::ST_RANGE)

endmodule

bind page_range_allocator_fit_top praf_checker u_praf_checker (.*);
`default_nettype wire
